// ----- sv/msp_pkg.sv -----
// shared types and constants for the markov successor prefetcher
`default_nettype none

package msp_pkg;

   localparam int ADDR_W = 64;

   typedef enum logic [7:0] {
      ST_CLEAR     = 8'b0000_0001,
      ST_IDLE      = 8'b0000_0010,
      ST_CUR_LOOK  = 8'b0000_0100,
      ST_CUR_EMIT  = 8'b0000_1000,
      ST_PREV_READ = 8'b0001_0000,
      ST_PREV_LOOK = 8'b0010_0000,
      ST_PREV_MOVE = 8'b0100_0000,
      ST_PREV_FIN  = 8'b1000_0000
   } state_type;

endpackage

`default_nettype wire

// ----- sv/msp_ram.sv -----
// generic single write port, single registered read port ram
`default_nettype none

module msp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word when the same address is written in that cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/markov_successor_prefetcher.sv -----
// top level of the markov successor prefetcher: sequencer, entry ram and successor ram
`default_nettype none

// usage
//  request: pulse start with req_access_address while busy is low; the address is
//    taken at that edge and busy rises at once
//  results: each prefetch address is shown for one cycle with rsp_valid high;
//    rsp_last_of_run marks the final one of a request; a miss or an empty list
//    gives no result at all; the receiver cannot stall, results are never held
//  sequence: the request edge starts the entry ram read; on a hit the successor
//    ram words follow, one per cycle, most recent successor first
//  busy covers the lookup, the results, the reread of the previous address's
//    entry and, if it is resident, the rewrite of its list; the single read
//    port of the successor ram sets the pace, one list word is read per cycle
//  the previous entry's list is rewritten in place: each word is read, dropped
//    if it matches the new address, else packed from slot one while slots last
//  reset: synchronous; afterwards the entry ram is swept, one entry a cycle,
//    over all TABLE_SETS entries with busy high, then the block is ready
//  TABLE_SETS must be a power of two, the set is the low address bits
module markov_successor_prefetcher
   import msp_pkg::*;
#(
   parameter int TABLE_SETS      = 256,
   parameter int SUCCESSOR_SLOTS = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [ADDR_W-1:0] req_access_address,
   output logic                   rsp_valid,
   output logic      [ADDR_W-1:0] rsp_prefetch_address,
   output logic                   rsp_last_of_run
);

   localparam int SET_W      = $clog2(TABLE_SETS);
   localparam int SLOT_W     = (SUCCESSOR_SLOTS > 1) ? $clog2(SUCCESSOR_SLOTS) : 1;
   localparam int CNT_W      = $clog2(SUCCESSOR_SLOTS + 1);
   localparam int META_W     = 1 + CNT_W + ADDR_W;
   localparam int LIST_AW    = SET_W + SLOT_W;
   localparam int LIST_DEPTH = TABLE_SETS * (2 ** SLOT_W);

   // sequencer state
   state_type         state_ff, state_in;
   logic [SET_W-1:0]  clr_ff, clr_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] prev_ff, prev_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  wpos_ff, wpos_in;
   logic              pend_ff, pend_in;
   logic              strobe_ff, strobe_in;
   logic              last_ff, last_in;

   // entry ram: valid, count, tag
   logic              meta_we, meta_re;
   logic [SET_W-1:0]  meta_waddr, meta_raddr;
   logic [META_W-1:0] meta_wdata, meta_rdata;

   // successor ram: one word per slot
   logic               list_we, list_re;
   logic [SET_W-1:0]   list_wset, list_rset;
   logic [SLOT_W-1:0]  list_wslot, list_rslot;
   logic [ADDR_W-1:0]  list_wdata, list_rdata;

   logic [SET_W-1:0]  set_cur, set_prev;
   logic              meta_valid;
   logic [CNT_W-1:0]  meta_cnt;
   logic [ADDR_W-1:0] meta_tag;
   logic              cur_hit, prev_hit;

   assign set_cur    = addr_ff[SET_W-1:0];
   assign set_prev   = prev_ff[SET_W-1:0];
   assign meta_valid = meta_rdata[META_W-1];
   assign meta_cnt   = meta_rdata[ADDR_W +: CNT_W];
   assign meta_tag   = meta_rdata[ADDR_W-1:0];
   assign cur_hit    = meta_valid && (meta_tag == addr_ff);
   assign prev_hit   = meta_valid && (meta_tag == prev_ff);

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      addr_in    = addr_ff;
      prev_in    = prev_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      wpos_in    = wpos_ff;
      pend_in    = pend_ff;
      strobe_in  = 1'b0;
      last_in    = 1'b0;
      meta_we    = 1'b0;
      meta_waddr = set_cur;
      meta_wdata = {1'b1, {CNT_W{1'b0}}, addr_ff};
      meta_re    = 1'b0;
      meta_raddr = set_prev;
      list_we    = 1'b0;
      list_wset  = set_prev;
      list_wslot = wpos_ff[SLOT_W-1:0];
      list_wdata = list_rdata;
      list_re    = 1'b0;
      list_rset  = set_cur;
      list_rslot = idx_ff[SLOT_W-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep every entry to invalid
            meta_we    = 1'b1;
            meta_waddr = clr_ff;
            meta_wdata = '0;
            clr_in     = clr_ff + SET_W'(1);
            if (clr_ff == SET_W'(TABLE_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               addr_in    = req_access_address;
               meta_re    = 1'b1;
               meta_raddr = req_access_address[SET_W-1:0];
               state_in   = ST_CUR_LOOK;
            end
         end
         ST_CUR_LOOK: begin
            if (cur_hit) begin
               if (meta_cnt != '0) begin
                  // first successor read, shown next cycle
                  cnt_in     = meta_cnt;
                  list_re    = 1'b1;
                  list_rslot = '0;
                  idx_in     = CNT_W'(1);
                  strobe_in  = 1'b1;
                  last_in    = (meta_cnt == CNT_W'(1));
                  state_in   = ST_CUR_EMIT;
               end else begin
                  state_in = ST_PREV_READ;
               end
            end else begin
               // miss: allocate with an empty list
               meta_we  = 1'b1;
               state_in = ST_PREV_READ;
            end
         end
         ST_CUR_EMIT: begin
            if (idx_ff != cnt_ff) begin
               list_re   = 1'b1;
               idx_in    = idx_ff + CNT_W'(1);
               strobe_in = 1'b1;
               last_in   = (idx_ff == cnt_ff - CNT_W'(1));
            end else begin
               state_in = ST_PREV_READ;
            end
         end
         ST_PREV_READ: begin
            // reread after a possible allocation into the same set
            meta_re  = 1'b1;
            state_in = ST_PREV_LOOK;
         end
         ST_PREV_LOOK: begin
            if (prev_hit) begin
               cnt_in     = meta_cnt;
               wpos_in    = CNT_W'(1);
               list_rset  = set_prev;
               list_rslot = '0;
               list_re    = (meta_cnt != '0);
               pend_in    = (meta_cnt != '0);
               idx_in     = (meta_cnt != '0) ? CNT_W'(1) : '0;
               state_in   = ST_PREV_MOVE;
            end else begin
               prev_in  = addr_ff;
               state_in = ST_IDLE;
            end
         end
         ST_PREV_MOVE: begin
            // keep words that differ from the new address, packed from slot one while slots last
            if (pend_ff && (list_rdata != addr_ff)
                && (wpos_ff != CNT_W'(SUCCESSOR_SLOTS))) begin
               list_we = 1'b1;
               wpos_in = wpos_ff + CNT_W'(1);
            end
            list_rset = set_prev;
            if (idx_ff != cnt_ff) begin
               list_re = 1'b1;
               idx_in  = idx_ff + CNT_W'(1);
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_PREV_FIN;
            end
         end
         ST_PREV_FIN: begin
            // new address at the front, count covers it and the kept words
            list_we    = 1'b1;
            list_wslot = '0;
            list_wdata = addr_ff;
            meta_we    = 1'b1;
            meta_waddr = set_prev;
            meta_wdata = {1'b1, wpos_ff, prev_ff};
            prev_in    = addr_ff;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         prev_ff   <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         prev_ff   <= prev_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      wpos_ff <= wpos_in;
   end

   msp_ram #(
      .WIDTH (META_W),
      .DEPTH (TABLE_SETS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_en   (meta_re),
      .rd_addr (meta_raddr),
      .rd_data (meta_rdata)
   );

   msp_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (LIST_DEPTH)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (list_we),
      .wr_addr ({list_wset, list_wslot}),
      .wr_data (list_wdata),
      .rd_en   (list_re),
      .rd_addr (LIST_AW'({list_rset, list_rslot})),
      .rd_data (list_rdata)
   );

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = strobe_ff;
   assign rsp_prefetch_address = list_rdata;
   assign rsp_last_of_run      = last_ff;

   // results only come out while a request is in progress
   a_rsp_while_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result outside a request");

   // a result not marked last is followed at once by another
   a_run_continues : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |=> rsp_valid)
      else $error("result run ended without last mark");

   // the last mark only rides on a result
   a_last_has_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_last_of_run |-> rsp_valid)
      else $error("last mark without result");

   // an accepted request keeps the block busy in the next cycle
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // the list write position never passes the slot count
   a_wpos_bound : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PREV_MOVE) || (state_ff == ST_PREV_FIN))
         |-> (wpos_ff <= CNT_W'(SUCCESSOR_SLOTS)))
      else $error("list write position out of range");

endmodule

`default_nettype wire

// ----- tb/markov_successor_prefetcher_checker.sv -----
// prefetch checker: predicts the successor list per request and compares each result
`timescale 1ns / 100ps

module markov_successor_prefetcher_checker
   import msp_pkg::*;
#(
   parameter int TABLE_SETS      = 256,
   parameter int SUCCESSOR_SLOTS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [ADDR_W-1:0] req_access_address,
   input  logic              rsp_valid,
   input  logic [ADDR_W-1:0] rsp_prefetch_address,
   input  logic              rsp_last_of_run,
   output int                error_count,
   output int                outstanding
);

   localparam int SET_W = $clog2(TABLE_SETS);

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic              last;
   } prefetch_t;

   logic              line_valid [TABLE_SETS];
   logic [ADDR_W-1:0] line_tag   [TABLE_SETS];
   logic [ADDR_W-1:0] line_succ  [TABLE_SETS][SUCCESSOR_SLOTS];
   int                line_count [TABLE_SETS];
   logic [ADDR_W-1:0] last_access;
   prefetch_t         pending_prefetches [$];
   int                mismatches;

   initial begin
      error_count = 0;
      outstanding = 0;
      mismatches  = 0;
   end

   function automatic int set_index(input logic [ADDR_W-1:0] a);
      return int'(a[SET_W-1:0]);
   endfunction

   function automatic bit is_resident(input logic [ADDR_W-1:0] a);
      return line_valid[set_index(a)] && line_tag[set_index(a)] == a;
   endfunction

   // drop any copy of the address, then push it on the front, oldest falls off
   task automatic promote_successor(input int s, input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] kept [SUCCESSOR_SLOTS];
      int n;
      n = 0;
      for (int i = 0; i < line_count[s]; i++) begin
         if (line_succ[s][i] != a) begin
            kept[n] = line_succ[s][i];
            n++;
         end
      end
      if (n >= SUCCESSOR_SLOTS) n = SUCCESSOR_SLOTS - 1;
      line_succ[s][0] = a;
      for (int i = 0; i < n; i++) line_succ[s][i + 1] = kept[i];
      line_count[s] = n + 1;
   endtask

   task automatic predict_prefetches(input logic [ADDR_W-1:0] a);
      int s;
      prefetch_t p;
      s = set_index(a);
      if (is_resident(a)) begin
         for (int k = 0; k < line_count[s]; k++) begin
            p.address = line_succ[s][k];
            p.last    = (k == line_count[s] - 1);
            pending_prefetches.push_back(p);
         end
      end else begin
         line_valid[s] = 1'b1;
         line_tag[s]   = a;
         line_count[s] = 0;
      end
      if (is_resident(last_access)) promote_successor(set_index(last_access), a);
      last_access = a;
   endtask

   task automatic check_prefetch();
      prefetch_t want;
      if (pending_prefetches.size() == 0) begin
         $display("%0t: unexpected prefetch, expected none, got address %h last %b",
                  $time, rsp_prefetch_address, rsp_last_of_run);
         mismatches++;
      end else begin
         want = pending_prefetches.pop_front();
         if (rsp_prefetch_address !== want.address) begin
            $display("%0t: prefetch address expected %h, got %h",
                     $time, want.address, rsp_prefetch_address);
            mismatches++;
         end
         if (rsp_last_of_run !== want.last) begin
            $display("%0t: last of run expected %b, got %b",
                     $time, want.last, rsp_last_of_run);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_SETS; i++) begin
            line_valid[i] = 1'b0;
            line_count[i] = 0;
         end
         last_access = '0;
         pending_prefetches.delete();
      end else begin
         if (rsp_valid) check_prefetch();
         if (start && !busy) predict_prefetches(req_access_address);
      end
      error_count <= mismatches;
      outstanding <= pending_prefetches.size();
   end

endmodule

// ----- tb/markov_successor_prefetcher_tb.sv -----
// testbench top for the markov successor prefetcher: request stimulus and verdict
`timescale 1ns / 100ps

module markov_successor_prefetcher_tb;
   import msp_pkg::*;

   localparam int TABLE_SETS      = 256;
   localparam int SUCCESSOR_SLOTS = 4;
   localparam int RANDOM_REQUESTS = 300;
   localparam int CALM_TAIL       = 40;      // last requests go back to back
   localparam int POOL_SIZE       = 16;
   localparam int POOL_REFRESH    = 64;
   localparam int DRAIN_CYCLES    = 24;      // longer than the longest busy time
   localparam int CYCLE_LIMIT     = 100000;
   localparam int DIRECTED_COUNT  = 18;

   // directed walk: self successor, repeats, list fill and overflow, an address
   // already in the list, eviction of the previous entry, a hit with an empty list
   localparam logic [ADDR_W-1:0] DIRECTED [DIRECTED_COUNT] = '{
      64'h0000_0000_0000_0000,   // miss, then becomes its own successor
      64'h0000_0000_0000_0000,   // repeat: hit on the old list
      64'hFFFF_FFFF_FFFF_FFFF,
      64'h0000_0000_0000_0000,
      64'hAAAA_AAAA_AAAA_AAAA,
      64'h5555_5555_5555_5555,
      64'h0000_0000_0000_0000,
      64'h1234_5678_9ABC_DE01,
      64'h0000_0000_0000_0000,   // full list, four prefetches
      64'h8000_0000_0000_0002,   // oldest successor drops out
      64'h0000_0000_0000_0000,
      64'hAAAA_AAAA_AAAA_AAAA,   // already listed, moves to the front
      64'h0000_0000_0000_0000,
      64'h8000_0000_0000_0000,   // same set as zero: evicts the previous entry
      64'h0000_0000_0000_0000,   // miss again, previous entry gone
      64'h0000_0000_0000_0000,   // hit with an empty list
      64'hFFFF_FFFF_FFFF_FFFF,
      64'hFFFF_FFFF_FFFF_FFFF
   };

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [ADDR_W-1:0] req_access_address;
   logic              rsp_valid;
   logic [ADDR_W-1:0] rsp_prefetch_address;
   logic              rsp_last_of_run;
   int                error_count;
   int                outstanding;
   int                cycle_count = 0;
   logic [ADDR_W-1:0] hot_addresses [POOL_SIZE];

   markov_successor_prefetcher #(
      .TABLE_SETS      (TABLE_SETS),
      .SUCCESSOR_SLOTS (SUCCESSOR_SLOTS)
   ) uut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_access_address   (req_access_address),
      .rsp_valid            (rsp_valid),
      .rsp_prefetch_address (rsp_prefetch_address),
      .rsp_last_of_run      (rsp_last_of_run)
   );

   // watches both channels, keeps its own table and counts mismatches
   markov_successor_prefetcher_checker #(
      .TABLE_SETS      (TABLE_SETS),
      .SUCCESSOR_SLOTS (SUCCESSOR_SLOTS)
   ) prefetch_check (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_access_address   (req_access_address),
      .rsp_valid            (rsp_valid),
      .rsp_prefetch_address (rsp_prefetch_address),
      .rsp_last_of_run      (rsp_last_of_run),
      .error_count          (error_count),
      .outstanding          (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("markov_successor_prefetcher_tb: done, errors");
         $finish;
      end
   end

   // a small working set so lists build up: random high bits, a dozen sets
   // shared among sixteen addresses so some of them evict each other
   function automatic void refresh_hot_addresses();
      for (int i = 0; i < POOL_SIZE; i++) begin
         hot_addresses[i]      = {$urandom, $urandom};
         hot_addresses[i][7:0] = 8'($urandom_range(0, 11) * 21);
      end
   endfunction

   // one request; an optional idle burst first, either while the block is
   // still busy or after it has gone idle, so gaps land on every phase
   task automatic issue_request(input logic [ADDR_W-1:0] a, input bit allow_idle);
      int gap;
      gap = 0;
      if (allow_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
      if (gap > 0) begin
         start <= 1'b0;
         if ($urandom_range(0, 1) == 1) begin
            do @(posedge clock); while (busy);
         end
         repeat (gap) @(posedge clock);
      end
      // start stays high if the next request follows at once
      start              <= 1'b1;
      req_access_address <= a;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      logic [ADDR_W-1:0] a;
      bit                idle_ok;
      reset              <= 1'b1;
      start              <= 1'b0;
      req_access_address <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // the clearing sweep after reset just shows up as busy
      for (int i = 0; i < DIRECTED_COUNT; i++) issue_request(DIRECTED[i], 1'b1);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % POOL_REFRESH == 0) refresh_hot_addresses();
         // mostly the working set, now and then a stray address that just misses
         if ($urandom_range(0, 6) == 0) a = {$urandom, $urandom};
         else a = hot_addresses[$urandom_range(0, POOL_SIZE - 1)];
         // every third stretch of twenty runs without idling, as does the tail
         idle_ok = (n < RANDOM_REQUESTS - CALM_TAIL) && ((n / 20) % 3 != 2);
         issue_request(a, idle_ok);
      end
      start <= 1'b0;

      // let the last prefetches come out, then give a trailing miss time to finish
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && outstanding == 0)
         $display("markov_successor_prefetcher_tb: done, clean");
      else
         $display("markov_successor_prefetcher_tb: done, errors");
      $finish;
   end

endmodule

// ----- files.f -----
sv/msp_pkg.sv
sv/msp_ram.sv
sv/markov_successor_prefetcher.sv
tb/markov_successor_prefetcher_checker.sv
tb/markov_successor_prefetcher_tb.sv
